// ===== hdl/chip8_register_alu_top_defines.svh =====
// assertion macros used by chip8_register_alu_top
`ifndef CHIP8_REGISTER_ALU_TOP_DEFINES_SVH
`define CHIP8_REGISTER_ALU_TOP_DEFINES_SVH

// checked outside reset only
`define C8ALU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define C8ALU_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/c8alu_pkg.sv =====
package c8alu_pkg;

  localparam int RegAddrW = 4;
  localparam int RegDepth = 16;
  localparam int DataW    = 8;

  // register F holds the flag
  localparam logic [RegAddrW-1:0] FlagIdx = 4'hF;

  typedef enum logic [3:0] {
    CMD_LDI   = 4'd0,
    CMD_ADDI  = 4'd1,
    CMD_MOV   = 4'd2,
    CMD_OR    = 4'd3,
    CMD_AND   = 4'd4,
    CMD_XOR   = 4'd5,
    CMD_ADD   = 4'd6,
    CMD_SUB   = 4'd7,
    CMD_SUBN  = 4'd8,
    CMD_SHR   = 4'd9,
    CMD_SHL   = 4'd10,
    CMD_SEQ_I = 4'd11,
    CMD_SNE_I = 4'd12,
    CMD_SEQ_Y = 4'd13,
    CMD_SNE_Y = 4'd14
  } cmd_e;

  typedef struct packed {
    logic [3:0]          cmd;
    logic [RegAddrW-1:0] x_index;
    logic [RegAddrW-1:0] y_index;
    logic [DataW-1:0]    immediate;
  } in_t;

  typedef struct packed {
    logic             skip;
    logic [DataW-1:0] x_value;
    logic [DataW-1:0] flag_value;
  } out_t;

  // what one operation writes back
  typedef struct packed {
    logic             skip;
    logic             x_we;
    logic [DataW-1:0] x_data;
    logic             f_we;
    logic [DataW-1:0] f_data;
  } exec_t;

endpackage

// ===== hdl/chip8_register_alu_top.sv =====
// path: each operation is registered in stage 1, then in the output register, before out_valid_o
// throughput: one operation per cycle unless out_stall_i holds the output, limited by the
//   single register file write port (registers 0 to 14 live in the ram, the flag in a flop)
// reset: all registers read as zero, pipeline empty, no result pending;
//   per-entry valid bits stand in for clearing the ram
`include "chip8_register_alu_top_defines.svh"

module chip8_register_alu_top import c8alu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // registered copy of the last ram write, kept for forwarding
  typedef struct packed {
    logic                valid;
    logic [RegAddrW-1:0] addr;
    logic [DataW-1:0]    data;
  } fwd_t;

  // stage 1: ram read data arrives for the item held here
  logic s1_valid_q;
  in_t  s1_data_q;
  logic s1_adv;
  logic s1_hold;

  // output register
  logic out_valid_q;
  out_t out_data_q;
  logic out_ready;

  // flag register and valid bits of the ram entries
  logic [DataW-1:0]    f_q;
  logic [RegDepth-1:0] vld_q;
  logic                x_vld_q;
  logic                y_vld_q;

  fwd_t fwd_q;

  logic [RegAddrW-1:0] raddr_x;
  logic [RegAddrW-1:0] raddr_y;
  logic [DataW-1:0]    ram_x;
  logic [DataW-1:0]    ram_y;
  logic                ram_we;

  logic [DataW-1:0] vx;
  logic [DataW-1:0] vy;
  logic [DataW-1:0] f_next;
  logic [DataW-1:0] x_after;
  logic             x_is_f;
  exec_t            res;

  // handshake: stage 1 moves on whenever the output register can take it
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign s1_hold    = s1_valid_q && !out_ready;
  assign in_stall_o = s1_hold;

  // while stage 1 holds, read its own registers again so that the data stays current
  assign raddr_x = s1_hold ? s1_data_q.x_index : in_data_i.x_index;
  assign raddr_y = s1_hold ? s1_data_q.y_index : in_data_i.y_index;

  c8alu_ram #(
    .Width(DataW),
    .Depth(RegDepth)
  ) u_regs (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (s1_data_q.x_index),
    .wdata_i  (res.x_data),
    .raddr_a_i(raddr_x),
    .rdata_a_o(ram_x),
    .raddr_b_i(raddr_y),
    .rdata_b_o(ram_y)
  );

  // operand select: flag flop, then forwarded write, then ram (zero if never written)
  always_comb begin
    if (s1_data_q.x_index == FlagIdx) begin
      vx = f_q;
    end else if (fwd_q.valid && fwd_q.addr == s1_data_q.x_index) begin
      vx = fwd_q.data;
    end else begin
      vx = x_vld_q ? ram_x : '0;
    end
    if (s1_data_q.y_index == FlagIdx) begin
      vy = f_q;
    end else if (fwd_q.valid && fwd_q.addr == s1_data_q.y_index) begin
      vy = fwd_q.data;
    end else begin
      vy = y_vld_q ? ram_y : '0;
    end
  end

  assign x_is_f = (s1_data_q.x_index == FlagIdx);

  c8alu_exec u_exec (
    .cmd_i   (s1_data_q.cmd),
    .x_is_f_i(x_is_f),
    .vx_i    (vx),
    .vy_i    (vy),
    .imm_i   (s1_data_q.immediate),
    .res_o   (res)
  );

  assign ram_we  = s1_adv && res.x_we;
  assign f_next  = res.f_we ? res.f_data : f_q;
  assign x_after = x_is_f ? f_next : (res.x_we ? res.x_data : vx);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      f_q         <= '0;
      vld_q       <= '0;
      fwd_q       <= '0;
    end else begin
      if (!s1_hold) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv && res.f_we) begin
        f_q <= res.f_data;
      end
      if (ram_we) begin
        vld_q[s1_data_q.x_index] <= 1'b1;
      end
      fwd_q.valid <= ram_we;
      fwd_q.addr  <= s1_data_q.x_index;
      fwd_q.data  <= res.x_data;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (!s1_hold) begin
      s1_data_q <= in_data_i;
    end
    // valid bits sampled with the ram read, same timing
    x_vld_q <= vld_q[raddr_x];
    y_vld_q <= vld_q[raddr_y];
    if (s1_adv) begin
      out_data_q.skip       <= res.skip;
      out_data_q.x_value    <= x_after;
      out_data_q.flag_value <= f_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // the flag never lands in the ram
  `C8ALU_ASSERT_ALWAYS(a_no_flag_in_ram, !ram_we || s1_data_q.x_index != FlagIdx, "flag written to ram")
  // a skip test writes nothing back
  `C8ALU_ASSERT(a_skip_no_write, !res.skip || (!res.x_we && !res.f_we), "skip op writes registers")
  // forwarding only right after a ram write
  `C8ALU_ASSERT(a_fwd_after_write, fwd_q.valid |-> $past(ram_we), "stale forwarding entry")
  // a retired operation always produces a pending result
  `C8ALU_ASSERT(a_adv_gives_result, s1_adv |=> out_valid_q, "retired op lost")

endmodule

// ===== hdl/c8alu_ram.sv =====
module c8alu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  output logic [Width-1:0] rdata_a_o,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hdl/c8alu_exec.sv =====
module c8alu_exec import c8alu_pkg::*; (
  input  logic [3:0]       cmd_i,
  input  logic             x_is_f_i,
  input  logic [DataW-1:0] vx_i,
  input  logic [DataW-1:0] vy_i,
  input  logic [DataW-1:0] imm_i,
  output exec_t            res_o
);

  logic [DataW-1:0] x_res;
  logic             x_wr;
  logic             flg;
  logic             flg_wr;
  logic             flag_wins;
  logic             skip;
  logic [DataW:0]   sum;

  always_comb begin
    sum       = {1'b0, vx_i} + {1'b0, vy_i};
    x_res     = vx_i;
    x_wr      = 1'b0;
    flg       = 1'b0;
    flg_wr    = 1'b0;
    flag_wins = 1'b0;
    skip      = 1'b0;
    unique case (cmd_e'(cmd_i))
      CMD_LDI: begin
        x_res = imm_i;
        x_wr  = 1'b1;
      end
      CMD_ADDI: begin
        x_res = vx_i + imm_i;
        x_wr  = 1'b1;
      end
      CMD_MOV: begin
        x_res = vy_i;
        x_wr  = 1'b1;
      end
      CMD_OR: begin
        x_res = vx_i | vy_i;
        x_wr  = 1'b1;
      end
      CMD_AND: begin
        x_res = vx_i & vy_i;
        x_wr  = 1'b1;
      end
      CMD_XOR: begin
        x_res = vx_i ^ vy_i;
        x_wr  = 1'b1;
      end
      CMD_ADD: begin
        x_res  = sum[DataW-1:0];
        x_wr   = 1'b1;
        flg    = sum[DataW];
        flg_wr = 1'b1;
      end
      CMD_SUB: begin
        x_res  = vx_i - vy_i;
        x_wr   = 1'b1;
        flg    = (vx_i >= vy_i);
        flg_wr = 1'b1;
      end
      CMD_SUBN: begin
        x_res  = vy_i - vx_i;
        x_wr   = 1'b1;
        flg    = (vy_i >= vx_i);
        flg_wr = 1'b1;
      end
      CMD_SHR: begin
        x_res     = {1'b0, vx_i[DataW-1:1]};
        x_wr      = 1'b1;
        flg       = vx_i[0];
        flg_wr    = 1'b1;
        flag_wins = 1'b1;
      end
      CMD_SHL: begin
        x_res     = {vx_i[DataW-2:0], 1'b0};
        x_wr      = 1'b1;
        flg       = vx_i[DataW-1];
        flg_wr    = 1'b1;
        flag_wins = 1'b1;
      end
      CMD_SEQ_I: skip = (vx_i == imm_i);
      CMD_SNE_I: skip = (vx_i != imm_i);
      CMD_SEQ_Y: skip = (vx_i == vy_i);
      CMD_SNE_Y: skip = (vx_i != vy_i);
      default: begin
      end
    endcase

    res_o.skip   = skip;
    res_o.x_data = x_res;
    if (x_is_f_i) begin
      // destination is the flag register itself
      res_o.x_we   = 1'b0;
      res_o.f_we   = x_wr | flg_wr;
      res_o.f_data = (flg_wr && (flag_wins || !x_wr)) ? {{(DataW-1){1'b0}}, flg} : x_res;
    end else begin
      res_o.x_we   = x_wr;
      res_o.f_we   = flg_wr;
      res_o.f_data = {{(DataW-1){1'b0}}, flg};
    end
  end

endmodule
